// ===== hdl/mfsk16_fec_symbol_encoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// mfsk16 encoder assertion macros
// shared concurrent assertion forms for the encoder checks
// ----------------------------------------------------------------------------
`ifndef MFSK16_FEC_SYMBOL_ENCODER_UNIT_DEFINES_SVH
`define MFSK16_FEC_SYMBOL_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MFSK_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfsk encoder check failed");

// next-cycle implication, checked outside reset
`define MFSK_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfsk encoder check failed");

`endif

// ===== hdl/mfsk_pkg.sv =====
// ----------------------------------------------------------------------------
// mfsk encoder package
// command codes, code constants, varicode rom and shared types
// ----------------------------------------------------------------------------
`default_nettype none

package mfsk_pkg;

    localparam int ILV_SIZE       = 4;
    localparam int ILV_STAGES_DEF = 10;
    localparam int VC_BITS        = 12;
    localparam int VC_LEN_W       = 4;
    localparam int HIST_W         = 6;

    localparam logic [HIST_W:0] POLY_A = 7'h6d;
    localparam logic [HIST_W:0] POLY_B = 7'h4f;

    localparam logic [15:0] CHAR_NL = 16'd10;
    localparam logic [6:0]  CHAR_CR = 7'd13;
    localparam logic [6:0]  CHAR_SP = 7'd32;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BIT   = 2'd1,
        CMD_CHAR  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } ilv_ctrl_t;

    typedef struct packed {
        logic [VC_LEN_W-1:0] len;
        logic [VC_BITS-1:0]  bits;
    } vc_entry_t;

    // length and code, right aligned
    localparam logic [VC_LEN_W+VC_BITS-1:0] VC_ROM [128] = '{
        {4'd11, 12'b11101011100}, {4'd11, 12'b11101100000}, {4'd11, 12'b11101101000},
        {4'd11, 12'b11101101100}, {4'd11, 12'b11101110000}, {4'd11, 12'b11101110100},
        {4'd11, 12'b11101111000}, {4'd11, 12'b11101111100},
        {4'd8,  12'b10101000},    {4'd11, 12'b11110000000}, {4'd11, 12'b11110100000},
        {4'd11, 12'b11110101000}, {4'd11, 12'b11110101100}, {4'd8,  12'b10101100},
        {4'd11, 12'b11110110000}, {4'd11, 12'b11110110100},
        {4'd11, 12'b11110111000}, {4'd11, 12'b11110111100}, {4'd11, 12'b11111000000},
        {4'd11, 12'b11111010000}, {4'd11, 12'b11111010100}, {4'd11, 12'b11111011000},
        {4'd11, 12'b11111011100}, {4'd11, 12'b11111100000},
        {4'd11, 12'b11111101000}, {4'd11, 12'b11111101100}, {4'd11, 12'b11111110000},
        {4'd11, 12'b11111110100}, {4'd11, 12'b11111111000}, {4'd11, 12'b11111111100},
        {4'd12, 12'b100000000000}, {4'd12, 12'b101000000000},
        {4'd3,  12'b100},         {4'd9,  12'b111000000},   {4'd9,  12'b111111100},
        {4'd10, 12'b1011011000},  {4'd10, 12'b1010101000},  {4'd10, 12'b1010100000},
        {4'd10, 12'b1000000000},  {4'd9,  12'b110111100},
        {4'd9,  12'b111110100},   {4'd9,  12'b111110000},   {4'd10, 12'b1010110100},
        {4'd9,  12'b111100000},   {4'd8,  12'b10100000},    {4'd9,  12'b111011000},
        {4'd9,  12'b111010100},   {4'd9,  12'b111101000},
        {4'd8,  12'b11100000},    {4'd8,  12'b11110000},    {4'd9,  12'b101000000},
        {4'd9,  12'b101010100},   {4'd9,  12'b101110100},   {4'd9,  12'b101100000},
        {4'd9,  12'b101101100},   {4'd9,  12'b110100000},
        {4'd9,  12'b110000000},   {4'd9,  12'b110101100},   {4'd9,  12'b111101100},
        {4'd9,  12'b111111000},   {4'd10, 12'b1011000000},  {4'd9,  12'b111011100},
        {4'd10, 12'b1010111100},  {4'd9,  12'b111010000},
        {4'd10, 12'b1010000000},  {4'd8,  12'b10111100},    {4'd9,  12'b100000000},
        {4'd8,  12'b11010100},    {4'd8,  12'b11011100},    {4'd8,  12'b10111000},
        {4'd8,  12'b11111000},    {4'd9,  12'b101010000},
        {4'd9,  12'b101011000},   {4'd8,  12'b11000000},    {4'd9,  12'b110110100},
        {4'd9,  12'b101111100},   {4'd8,  12'b11110100},    {4'd8,  12'b11101000},
        {4'd8,  12'b11111100},    {4'd8,  12'b11010000},
        {4'd8,  12'b11101100},    {4'd9,  12'b110110000},   {4'd8,  12'b11011000},
        {4'd8,  12'b10110100},    {4'd8,  12'b10110000},    {4'd9,  12'b101011100},
        {4'd9,  12'b110101000},   {4'd9,  12'b101101000},
        {4'd9,  12'b101110000},   {4'd9,  12'b101111000},   {4'd9,  12'b110111000},
        {4'd10, 12'b1011101000},  {4'd10, 12'b1011010000},  {4'd10, 12'b1011101100},
        {4'd10, 12'b1011010100},  {4'd10, 12'b1010110000},
        {4'd10, 12'b1010101100},  {4'd5,  12'b10100},       {4'd7,  12'b1100000},
        {4'd6,  12'b111000},      {4'd6,  12'b110100},      {4'd4,  12'b1000},
        {4'd7,  12'b1010000},     {4'd7,  12'b1011000},
        {4'd6,  12'b110000},      {4'd5,  12'b11000},       {4'd8,  12'b10000000},
        {4'd7,  12'b1110000},     {4'd6,  12'b101100},      {4'd7,  12'b1000000},
        {4'd5,  12'b11100},       {4'd5,  12'b10000},
        {4'd7,  12'b1010100},     {4'd7,  12'b1111000},     {4'd6,  12'b100000},
        {4'd6,  12'b101000},      {4'd4,  12'b1100},        {4'd6,  12'b111100},
        {4'd7,  12'b1101100},     {4'd7,  12'b1101000},
        {4'd7,  12'b1110100},     {4'd7,  12'b1011100},     {4'd7,  12'b1111100},
        {4'd10, 12'b1011011100},  {4'd10, 12'b1010111000},  {4'd10, 12'b1011100000},
        {4'd10, 12'b1011110000},  {4'd12, 12'b101010000000}
    };

    // rom entry with the code moved up so that its first bit is the msb
    function automatic vc_entry_t vc_lookup(input logic [6:0] code);
        vc_entry_t raw;
        vc_entry_t res;
        raw      = VC_ROM[code];
        res.len  = raw.len;
        res.bits = raw.bits << (VC_LEN_W'(VC_BITS) - raw.len);
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mfsk16_fec_symbol_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// mfsk16 fec symbol encoder
// varicode, k=7 rate 1/2 convolutional code, diagonal interleaver, gray tones
// ----------------------------------------------------------------------------
//
//  channel | signals                      | direction | request
//  --------+------------------------------+-----------+----------------------
//  in      | in_valid in_ready            | sink      | cmd character bit_value
//  out     | out_valid out_ready          | source    | tone last
//
//  a character request loads its varicode bits (3 to 12) into the varicode
//  bit shift register, which then sends one bit per step; a raw bit loads a
//  single bit, and start and unused codes leave the block idle.
//  every second coded data bit makes one tone; that step waits while the
//  output register still holds a tone that has not been taken.
//  rst_n clears all but bits_reg, tone_reg and last_reg at once, no clearing pass.
//
`default_nettype none

module mfsk16_fec_symbol_encoder_unit #(
    parameter int INTERLEAVE_STAGES = mfsk_pkg::ILV_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [15:0] character,
    input  logic        bit_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  tone,
    output logic        last
);
    import mfsk_pkg::*;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                state_reg, state_next;

    // varicode bits still to send, msb first, and how many are left
    logic [VC_BITS-1:0]    bits_reg, bits_next;
    logic [VC_LEN_W-1:0]   left_reg, left_next;

    // convolutional encoder history and the held pair of coded bits
    logic [HIST_W-1:0]     hist_reg, hist_next;
    logic [1:0]            pair_reg, pair_next;
    logic                  half_reg, half_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [ILV_SIZE-1:0]   tone_reg, tone_next;
    logic                  last_reg, last_next;

    logic                  in_fire;
    logic [6:0]            code;
    vc_entry_t             vc;
    logic [HIST_W:0]       shift7;
    logic                  coded_a;
    logic                  coded_b;
    logic                  can_load;
    logic                  step;
    logic                  load;
    ilv_ctrl_t             ilv_ctrl;
    logic [ILV_SIZE-1:0]   ilv_tone;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign tone      = tone_reg;
    assign last      = last_reg;

    // newline goes out as carriage return, anything above ascii as space
    always_comb
    begin
        if (character == CHAR_NL)
        begin
            code = CHAR_CR;
        end
        else if (|character[15:7])
        begin
            code = CHAR_SP;
        end
        else
        begin
            code = character[6:0];
        end
    end

    assign vc = vc_lookup(code);

    // encoder taps on history plus the current data bit
    assign shift7  = {hist_reg, bits_reg[VC_BITS-1]};
    assign coded_a = ^(shift7 & POLY_A);
    assign coded_b = ^(shift7 & POLY_B);

    // a tone is due when a pair of coded bits is already held
    assign can_load = !out_valid_reg || out_ready;
    assign step     = (state_reg == ST_RUN) && (!half_reg || can_load);
    assign load     = step && half_reg;

    assign ilv_ctrl.clear = in_fire && (cmd == CMD_START);
    assign ilv_ctrl.shift = load;

    mfsk_ilv #(
        .STAGES (INTERLEAVE_STAGES)
    ) u_ilv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ilv_ctrl),
        .nibble ({pair_reg, coded_a, coded_b}),
        .tone   (ilv_tone)
    );

    always_comb
    begin
        state_next = state_reg;
        bits_next  = bits_reg;
        left_next  = left_reg;
        hist_next  = hist_reg;
        pair_next  = pair_reg;
        half_next  = half_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (cmd)
                        CMD_START:
                        begin
                            hist_next = '0;
                            pair_next = '0;
                            half_next = 1'b0;
                        end
                        CMD_BIT:
                        begin
                            bits_next  = {bit_value, {(VC_BITS-1){1'b0}}};
                            left_next  = VC_LEN_W'(1);
                            state_next = ST_RUN;
                        end
                        CMD_CHAR:
                        begin
                            bits_next  = vc.bits;
                            left_next  = vc.len;
                            state_next = ST_RUN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (step)
                begin
                    hist_next = shift7[HIST_W-1:0];
                    bits_next = bits_reg << 1;
                    left_next = left_reg - VC_LEN_W'(1);
                    if (half_reg)
                    begin
                        pair_next = '0;
                        half_next = 1'b0;
                    end
                    else
                    begin
                        pair_next = {coded_a, coded_b};
                        half_next = 1'b1;
                    end
                    if (left_reg == VC_LEN_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // the tone is the last one of the request when fewer than two data
    // bits remain after this one, as a further tone needs two more bits
    always_comb
    begin
        out_valid_next = out_valid_reg;
        tone_next      = tone_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            tone_next      = ilv_tone;
            last_next      = (left_reg <= VC_LEN_W'(2));
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            hist_reg      <= '0;
            pair_reg      <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            hist_reg      <= hist_next;
            pair_reg      <= pair_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        tone_reg <= tone_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

// ===== hdl/mfsk_ilv.sv =====
// ----------------------------------------------------------------------------
// mfsk diagonal interleaver
// cascade of 4x4 shift cell stages with gray mapping of the result
// ----------------------------------------------------------------------------
`default_nettype none

module mfsk_ilv #(
    parameter int STAGES = mfsk_pkg::ILV_STAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mfsk_pkg::ilv_ctrl_t            ctrl,
    input  logic [mfsk_pkg::ILV_SIZE-1:0]  nibble,
    output logic [mfsk_pkg::ILV_SIZE-1:0]  tone
);
    import mfsk_pkg::*;

    // one row vector per stage and row, bit index is the column
    logic [ILV_SIZE-1:0] store_reg  [STAGES][ILV_SIZE];
    logic [ILV_SIZE-1:0] store_next [STAGES][ILV_SIZE];
    logic [ILV_SIZE-1:0] sym        [STAGES+1];
    logic [ILV_SIZE-1:0] result;

    genvar s, r;
    generate
        for (r = 0; r < ILV_SIZE; r++)
        begin : g_in
            assign sym[0][r] = nibble[ILV_SIZE-1-r];
            assign result[ILV_SIZE-1-r] = sym[STAGES][r];
        end
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            for (r = 0; r < ILV_SIZE; r++)
            begin : g_row
                // shift towards column 0, new bit enters the last column
                assign store_next[s][r] = {sym[s][r], store_reg[s][r][ILV_SIZE-1:1]};
                // diagonal tap
                assign sym[s+1][r] = store_next[s][r][ILV_SIZE-1-r];
            end
        end
    endgenerate

    assign tone = result ^ (result >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                for (int j = 0; j < ILV_SIZE; j++)
                begin
                    store_reg[i][j] <= '0;
                end
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                for (int j = 0; j < ILV_SIZE; j++)
                begin
                    store_reg[i][j] <= '0;
                end
            end
        end
        else if (ctrl.shift)
        begin
            store_reg <= store_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mfsk_chk.sv =====
// ----------------------------------------------------------------------------
// mfsk encoder port checker
// port level checks on request flow, bound to the encoder top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "mfsk16_fec_symbol_encoder_unit_defines.svh"

module mfsk_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  tone,
    input  logic        last
);
    import mfsk_pkg::*;

    logic req_fire;
    logic code_req;
    logic ctrl_req;
    logic tone_wait;

    assign req_fire  = in_valid && in_ready;
    assign code_req  = req_fire && (cmd == CMD_BIT || cmd == CMD_CHAR);
    assign ctrl_req  = req_fire && (cmd == CMD_START || cmd == CMD_NONE);
    assign tone_wait = out_valid && !out_ready;

    // a waiting tone holds
    `MFSK_ASSERT_NEXT(a_out_hold, clk, rst_n, tone_wait, (out_valid && $stable({tone, last})))

    // bit and character requests leave the block busy in the cycle after
    `MFSK_ASSERT_NEXT(a_busy_after_code, clk, rst_n, code_req, (!in_ready))

    // start and unused codes leave the block free
    `MFSK_ASSERT_NEXT(a_idle_after_ctrl, clk, rst_n, ctrl_req, (in_ready))

    // a tone that is not the last one means its request is still running
    `MFSK_ASSERT_IMP(a_more_tones_busy, clk, rst_n, (out_valid && !last), (!in_ready))

endmodule

bind mfsk16_fec_symbol_encoder_unit mfsk_chk u_mfsk_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tone      (tone),
    .last      (last)
);

`default_nettype wire
